// ===== rtl/sip_pkg.sv =====
// Shared types and constants for the set intersection probe.
package sip_pkg;

  localparam int ValueW = 32;
  localparam int TotalW = 12;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_PROBE  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

// ===== rtl/sip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/set_intersection_probe.sv =====
// Top level of the set intersection probe: sequencer, comparator and result register.
//
// Requests arrive on the in_ channel (in_valid / in_stall). A clear request
// empties the reference set and zeroes the match total; an append request
// writes value at the next free slot of the store (dropped when full). Both
// give no result. A probe request walks the stored entries in order with a
// single 32-bit comparator, reading each RAM entry with an address step and
// then a compare step, and gives one result per matching entry, or one miss
// result when nothing matches. Entries pass one at a time through the one
// RAM read port and the shared comparator; in_stall stays high for the
// whole walk.
// Results leave on the out_ channel (out_valid / out_stall) from an output
// register. One hit is held back until the next hit or the end of the walk
// so that the last result of a probe carries last and, for the final probe
// of a set, set_done; the match total then returns to zero.
// A stalled receiver holds the walk at the comparator on a new hit while an
// earlier hit is held, and at the end of the walk, until the output register
// frees up. Reset empties the set and zeroes the total; the store is not cleared.
module set_intersection_probe #(
  parameter int SET_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic signed [sip_pkg::ValueW-1:0] value,
  input  logic                          probe_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [sip_pkg::ValueW-1:0] match_value,
  output logic                          last,
  output logic                          set_done,
  output logic [sip_pkg::TotalW-1:0]    match_total
);
  import sip_pkg::*;

  localparam int AddrW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CntW  = $clog2(SET_DEPTH + 1);

  state_t            state;
  logic [CntW-1:0]   ref_count;
  logic [CntW-1:0]   idx;
  logic [TotalW-1:0] total_matches;
  logic [ValueW-1:0] probe_value;
  logic              probe_fin;
  logic              pend_valid;
  logic [TotalW-1:0] pend_total;

  logic              accept;
  logic              out_free;
  logic              ram_wr_en;
  logic [ValueW-1:0] ram_rd_data;
  logic              entry_match;
  logic [TotalW-1:0] total_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign ram_wr_en = accept && (req_t'(req_type) == REQ_APPEND)
                     && (ref_count < CntW'(SET_DEPTH));
  assign entry_match = (ram_rd_data == probe_value);
  assign total_inc   = (total_matches == TotalMax) ? total_matches
                                                   : total_matches + 1'b1;

  sip_ram #(
    .WIDTH(ValueW),
    .DEPTH(SET_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ref_count[AddrW-1:0]),
    .wr_data(value),
    .rd_addr(idx[AddrW-1:0]),
    .rd_data(ram_rd_data)
  );

  // Sequencer, running total and held-back hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ref_count     <= '0;
      total_matches <= '0;
      idx           <= '0;
      pend_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_t'(req_type))
              REQ_CLEAR: begin
                ref_count     <= '0;
                total_matches <= '0;
              end
              REQ_APPEND: begin
                if (ram_wr_en) begin
                  ref_count <= ref_count + 1'b1;
                end
              end
              REQ_PROBE: begin
                idx        <= '0;
                pend_valid <= 1'b0;
                state      <= (ref_count == '0) ? ST_FINISH : ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          // hold a new hit while an earlier hit cannot leave yet
          if (!(entry_match && pend_valid && !out_free)) begin
            if (entry_match) begin
              total_matches <= total_inc;
              pend_valid    <= 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= (idx + 1'b1 == ref_count) ? ST_FINISH : ST_READ;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            if (probe_fin) begin
              total_matches <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_t'(req_type) == REQ_PROBE)) begin
      probe_value <= value;
      probe_fin   <= probe_last;
    end
    if (state == ST_CMP && entry_match && (!pend_valid || out_free)) begin
      pend_total <= total_inc;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_CMP && entry_match && pend_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP && entry_match && pend_valid && out_free) begin
      hit         <= 1'b1;
      match_value <= probe_value;
      last        <= 1'b0;
      set_done    <= 1'b0;
      match_total <= pend_total;
    end else if (state == ST_FINISH && out_free) begin
      hit         <= pend_valid;
      match_value <= pend_valid ? probe_value : '0;
      last        <= 1'b1;
      set_done    <= probe_fin;
      match_total <= total_matches;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= CntW'(SET_DEPTH))
    else $error("reference count beyond store depth");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && set_done |-> last)
    else $error("set_done without last");

  a_hit_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> match_total != '0)
    else $error("hit result with zero total");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> idx < ref_count)
    else $error("compare index past stored entries");

endmodule
